// File: rtl/mffn_pkg.sv
// Package for the maze flood-fill navigator: sequencer states, codes and constants.
// Used by the top level; depends on nothing.
package mffn_pkg;

  // Default maze edge length in cells.
  localparam int GRID_SIZE_DEF = 16;

  // Distance map encoding.
  localparam int          DIST_W    = 8;
  localparam logic [7:0]  UNREACHED = 8'd255;
  localparam logic [7:0]  MAX_LEVEL = 8'd254;

  // Turn codes.
  localparam logic [1:0] TURN_NONE = 2'd0;

  // Heading codes, also the bit positions in a cell's wall nibble.
  localparam logic [1:0] DIR_NORTH = 2'd0;
  localparam logic [1:0] DIR_EAST  = 2'd1;
  localparam logic [1:0] DIR_SOUTH = 2'd2;
  localparam logic [1:0] DIR_WEST  = 2'd3;

  // Strategy register values.
  localparam logic STRAT_FLOOD  = 1'b0;
  localparam logic STRAT_FOLLOW = 1'b1;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WUPD,
    ST_DCLR,
    ST_SEED,
    ST_POP,
    ST_QWAIT,
    ST_CELL,
    ST_NREAD,
    ST_NCHK,
    ST_CWALL,
    ST_CAND,
    ST_CANDW,
    ST_FOLLOW,
    ST_MOVE,
    ST_DONE
  } state_t;

endpackage

// File: rtl/mffn_in_if.sv
// Input channel of the navigator: one item carries the four sensed walls.
// Standalone interface; no package needed.
interface mffn_in_if;
  logic valid;
  logic ready;
  logic wall_north;
  logic wall_east;
  logic wall_south;
  logic wall_west;

  modport source (output valid, output wall_north, output wall_east,
                  output wall_south, output wall_west, input ready);
  modport sink   (input valid, input wall_north, input wall_east,
                  input wall_south, input wall_west, output ready);
endinterface

// File: rtl/mffn_out_if.sv
// Result channel of the navigator: one item carries the move that was made.
// Standalone interface; no package needed.
interface mffn_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] turn;
  logic [1:0] heading;
  logic [3:0] new_row;
  logic [3:0] new_col;
  logic       at_goal;
  logic       stuck;
  logic [7:0] cell_distance;

  modport source (output valid, output turn, output heading, output new_row,
                  output new_col, output at_goal, output stuck,
                  output cell_distance, input ready);
  modport sink   (input valid, input turn, input heading, input new_row,
                  input new_col, input at_goal, input stuck,
                  input cell_distance, output ready);
endinterface

// File: rtl/maze_flood_fill_navigator.sv
// Maze navigator top level: wall map, distance map, flood queue and sequencer.
// Depends on mffn_pkg, mffn_in_if and mffn_out_if.
//
//  Channel | Direction | Handshake         | Content
//  in_ch   | sink      | valid/ready       | wall_north, wall_east, wall_south, wall_west
//  out_ch  | source    | valid/ready       | turn, heading, new_row, new_col, at_goal,
//          |           |                   | stuck, cell_distance
//  cfg     | write     | cfg_we, no wait   | strategy
//
// After reset a clearing pass sweeps all GRID_SIZE*GRID_SIZE cells (256 by default) of
// the wall and distance memories; no item is accepted meanwhile.
// In flood strategy an item merges the sensed walls into the wall map, clears the
// distance map, floods it from the four centre cells through a queue and then moves
// the robot to its open neighbour of least distance; all distance reads share the
// single read port of the distance memory. In wall-follower strategy the move comes
// straight from the sensed walls and the maze edge.
// One item is in work at a time; a finished result waits in the output register and the
// next item is accepted once the sequencer is back in idle.
module maze_flood_fill_navigator
  import mffn_pkg::*;
#(
  parameter int GRID_SIZE = GRID_SIZE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  mffn_in_if.sink    in_ch,
  mffn_out_if.source out_ch
);

  localparam int ROW_W  = $clog2(GRID_SIZE);
  localparam int NCELLS = GRID_SIZE * GRID_SIZE;
  localparam int CELL_W = $clog2(NCELLS);
  localparam int GOAL_LO = GRID_SIZE / 2 - 1;
  localparam int GOAL_HI = GRID_SIZE / 2;

  // Cell address from row and column.
  function automatic logic [CELL_W-1:0] cell_idx(input logic [ROW_W-1:0] row,
                                                 input logic [ROW_W-1:0] col);
    logic [CELL_W-1:0] prod;
    prod = CELL_W'(row) * CELL_W'(GRID_SIZE);
    return prod + CELL_W'(col);
  endfunction

  // Maze edge walls of a cell, bit 0 north to bit 3 west.
  function automatic logic [3:0] border(input logic [ROW_W-1:0] row,
                                        input logic [ROW_W-1:0] col);
    return {col == ROW_W'(0), row == ROW_W'(GRID_SIZE - 1),
            col == ROW_W'(GRID_SIZE - 1), row == ROW_W'(0)};
  endfunction

  // Memories.
  logic [3:0]         wall_mem  [NCELLS];
  logic [DIST_W-1:0]  dist_mem  [NCELLS];
  logic [2*ROW_W-1:0] queue_mem [NCELLS];

  logic                 wall_we, dist_we, queue_we;
  logic [CELL_W-1:0]    wall_wa, wall_ra, dist_wa, dist_ra, queue_wa, queue_ra;
  logic [3:0]           wall_wd, wall_rd;
  logic [DIST_W-1:0]    dist_wd, dist_rd;
  logic [2*ROW_W-1:0]   queue_wd, queue_rd;

  // Registers.
  state_t             state_r, state_nxt;
  logic [CELL_W:0]    cnt_r, cnt_nxt;
  logic [CELL_W:0]    head_r, head_nxt, tail_r, tail_nxt;
  logic [1:0]         k_r, k_nxt;
  logic [ROW_W-1:0]   cur_row_r, cur_row_nxt, cur_col_r, cur_col_nxt;
  logic [3:0]         cwalls_r, cwalls_nxt;
  logic [DIST_W-1:0]  lvl_r, lvl_nxt, best_r, best_nxt;
  logic [1:0]         bdir_r, bdir_nxt;
  logic               found_r, found_nxt;
  logic [3:0]         sensed_r, sensed_nxt;
  logic [ROW_W-1:0]   rob_row_r, rob_row_nxt, rob_col_r, rob_col_nxt;
  logic [1:0]         rob_head_r, rob_head_nxt;
  logic [1:0]         turn_r, turn_nxt;
  logic               strategy_r;
  logic               out_vld_r, out_vld_nxt;
  logic [1:0]         o_turn_r, o_turn_nxt, o_head_r, o_head_nxt;
  logic [3:0]         o_row_r, o_row_nxt, o_col_r, o_col_nxt;
  logic               o_goal_r, o_goal_nxt, o_stuck_r, o_stuck_nxt;
  logic [DIST_W-1:0]  o_dist_r, o_dist_nxt;

  // Shared neighbour unit.
  logic [ROW_W-1:0] nb_base_row, nb_base_col, nb_row, nb_col;
  logic [1:0]       nb_dir;
  logic [CELL_W-1:0] rob_idx, cur_idx, nb_idx;
  logic              in_acc;
  logic [3:0]        fw_walls;
  logic [1:0]        fw_dir;
  logic              fw_found;
  logic              goal_now;

  assign rob_idx = cell_idx(rob_row_r, rob_col_r);
  assign cur_idx = cell_idx(cur_row_r, cur_col_r);
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  // Base cell and direction for the neighbour unit follow the sequencer state.
  always_comb begin
    if (state_r == ST_NREAD || state_r == ST_NCHK) begin
      nb_base_row = cur_row_r;
      nb_base_col = cur_col_r;
    end else begin
      nb_base_row = rob_row_r;
      nb_base_col = rob_col_r;
    end
    if (state_r == ST_CAND || state_r == ST_CANDW) begin
      nb_dir = ~k_r;
    end else if (state_r == ST_MOVE) begin
      nb_dir = bdir_r;
    end else begin
      nb_dir = k_r;
    end
  end

  always_comb begin
    nb_row = nb_base_row;
    nb_col = nb_base_col;
    case (nb_dir)
      DIR_NORTH: nb_row = nb_base_row - ROW_W'(1);
      DIR_EAST:  nb_col = nb_base_col + ROW_W'(1);
      DIR_SOUTH: nb_row = nb_base_row + ROW_W'(1);
      default:   nb_col = nb_base_col - ROW_W'(1);
    endcase
  end

  assign nb_idx = cell_idx(nb_row, nb_col);

  // Right-hand rule: right, front, left, back.
  always_comb begin
    logic [1:0] cand;
    fw_walls = sensed_r | border(rob_row_r, rob_col_r);
    fw_found = 1'b0;
    fw_dir   = rob_head_r;
    for (int i = 0; i < 4; i++) begin
      cand = rob_head_r + ((i == 0) ? 2'd1 : (i == 1) ? 2'd0 : (i == 2) ? 2'd3 : 2'd2);
      if (!fw_found && !fw_walls[cand]) begin
        fw_found = 1'b1;
        fw_dir   = cand;
      end
    end
  end

  assign goal_now = (rob_row_r == ROW_W'(GOAL_LO) || rob_row_r == ROW_W'(GOAL_HI)) &&
                    (rob_col_r == ROW_W'(GOAL_LO) || rob_col_r == ROW_W'(GOAL_HI));

  // Memory ports, written and read with registered data.
  always_ff @(posedge clk) begin
    if (wall_we) begin
      wall_mem[wall_wa] <= wall_wd;
    end
    wall_rd <= wall_mem[wall_ra];
  end

  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[dist_wa] <= dist_wd;
    end
    dist_rd <= dist_mem[dist_ra];
  end

  always_ff @(posedge clk) begin
    if (queue_we) begin
      queue_mem[queue_wa] <= queue_wd;
    end
    queue_rd <= queue_mem[queue_ra];
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strategy_r <= STRAT_FLOOD;
    end else if (cfg_we) begin
      strategy_r <= cfg_wdata;
    end
  end

  // Sequencer register and control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      cnt_r      <= '0;
      head_r     <= '0;
      tail_r     <= '0;
      rob_row_r  <= ROW_W'(GRID_SIZE - 1);
      rob_col_r  <= '0;
      rob_head_r <= DIR_NORTH;
      out_vld_r  <= 1'b0;
      found_r    <= 1'b0;
      k_r        <= '0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      rob_row_r  <= rob_row_nxt;
      rob_col_r  <= rob_col_nxt;
      rob_head_r <= rob_head_nxt;
      out_vld_r  <= out_vld_nxt;
      found_r    <= found_nxt;
      k_r        <= k_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cur_row_r <= cur_row_nxt;
    cur_col_r <= cur_col_nxt;
    cwalls_r  <= cwalls_nxt;
    lvl_r     <= lvl_nxt;
    best_r    <= best_nxt;
    bdir_r    <= bdir_nxt;
    sensed_r  <= sensed_nxt;
    turn_r    <= turn_nxt;
    o_turn_r  <= o_turn_nxt;
    o_head_r  <= o_head_nxt;
    o_row_r   <= o_row_nxt;
    o_col_r   <= o_col_nxt;
    o_goal_r  <= o_goal_nxt;
    o_stuck_r <= o_stuck_nxt;
    o_dist_r  <= o_dist_nxt;
  end

  // Next state, memory controls and datapath updates.
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    k_nxt        = k_r;
    cur_row_nxt  = cur_row_r;
    cur_col_nxt  = cur_col_r;
    cwalls_nxt   = cwalls_r;
    lvl_nxt      = lvl_r;
    best_nxt     = best_r;
    bdir_nxt     = bdir_r;
    found_nxt    = found_r;
    sensed_nxt   = sensed_r;
    rob_row_nxt  = rob_row_r;
    rob_col_nxt  = rob_col_r;
    rob_head_nxt = rob_head_r;
    turn_nxt     = turn_r;
    out_vld_nxt  = out_vld_r && !out_ch.ready;
    o_turn_nxt   = o_turn_r;
    o_head_nxt   = o_head_r;
    o_row_nxt    = o_row_r;
    o_col_nxt    = o_col_r;
    o_goal_nxt   = o_goal_r;
    o_stuck_nxt  = o_stuck_r;
    o_dist_nxt   = o_dist_r;

    wall_we  = 1'b0;
    wall_wa  = rob_idx;
    wall_wd  = wall_rd | sensed_r;
    wall_ra  = rob_idx;
    dist_we  = 1'b0;
    dist_wa  = nb_idx;
    dist_wd  = lvl_r;
    dist_ra  = rob_idx;
    queue_we = 1'b0;
    queue_wa = tail_r[CELL_W-1:0];
    queue_wd = {nb_row, nb_col};
    queue_ra = head_r[CELL_W-1:0];

    case (state_r)
      // Post-reset sweep: no sensed walls, every cell unreached.
      ST_CLEAR: begin
        wall_we = 1'b1;
        wall_wa = cnt_r[CELL_W-1:0];
        wall_wd = '0;
        dist_we = 1'b1;
        dist_wa = cnt_r[CELL_W-1:0];
        dist_wd = UNREACHED;
        if (cnt_r == (CELL_W+1)'(NCELLS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      // Wait for an item; the robot cell's walls are read all the while.
      ST_IDLE: begin
        if (in_acc) begin
          sensed_nxt = {in_ch.wall_west, in_ch.wall_south, in_ch.wall_east,
                        in_ch.wall_north};
          state_nxt  = (strategy_r == STRAT_FLOOD) ? ST_WUPD : ST_FOLLOW;
        end
      end

      // Merge the sensed walls into the wall map.
      ST_WUPD: begin
        wall_we   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_DCLR;
      end

      // Reset the distance map before the flood.
      ST_DCLR: begin
        dist_we = 1'b1;
        dist_wa = cnt_r[CELL_W-1:0];
        dist_wd = UNREACHED;
        if (cnt_r == (CELL_W+1)'(NCELLS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_SEED;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      // Seed the four centre cells at distance zero, row by row.
      ST_SEED: begin
        dist_we  = 1'b1;
        dist_wa  = cell_idx(ROW_W'(GOAL_LO) + ROW_W'(cnt_r[1]),
                            ROW_W'(GOAL_LO) + ROW_W'(cnt_r[0]));
        dist_wd  = '0;
        queue_we = 1'b1;
        queue_wa = CELL_W'(cnt_r[1:0]);
        queue_wd = {ROW_W'(GOAL_LO) + ROW_W'(cnt_r[1]),
                    ROW_W'(GOAL_LO) + ROW_W'(cnt_r[0])};
        if (cnt_r[1:0] == 2'd3) begin
          cnt_nxt   = '0;
          head_nxt  = '0;
          tail_nxt  = (CELL_W+1)'(4);
          state_nxt = ST_POP;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      // Take the next cell from the queue, or finish the flood.
      ST_POP: begin
        if (head_r == tail_r) begin
          state_nxt = ST_CWALL;
        end else begin
          head_nxt  = head_r + 1'b1;
          state_nxt = ST_QWAIT;
        end
      end

      // Queue entry arrives; fetch its walls and distance.
      ST_QWAIT: begin
        cur_row_nxt = queue_rd[2*ROW_W-1:ROW_W];
        cur_col_nxt = queue_rd[ROW_W-1:0];
        wall_ra     = cell_idx(queue_rd[2*ROW_W-1:ROW_W], queue_rd[ROW_W-1:0]);
        dist_ra     = wall_ra;
        state_nxt   = ST_CELL;
      end

      // Next level, saturated so that a reached cell never reads as unreached.
      ST_CELL: begin
        cwalls_nxt = wall_rd | border(cur_row_r, cur_col_r);
        lvl_nxt    = (dist_rd >= MAX_LEVEL) ? MAX_LEVEL : dist_rd + 1'b1;
        k_nxt      = '0;
        state_nxt  = ST_NREAD;
      end

      // Look at the neighbour on side k if that side is open.
      ST_NREAD: begin
        dist_ra = nb_idx;
        if (cwalls_r[k_r]) begin
          k_nxt     = k_r + 1'b1;
          state_nxt = (k_r == 2'd3) ? ST_POP : ST_NREAD;
        end else begin
          state_nxt = ST_NCHK;
        end
      end

      // Claim an unreached neighbour and queue it.
      ST_NCHK: begin
        if (dist_rd == UNREACHED) begin
          dist_we = 1'b1;
          if (tail_r < (CELL_W+1)'(NCELLS)) begin
            queue_we = 1'b1;
            tail_nxt = tail_r + 1'b1;
          end
        end
        k_nxt     = k_r + 1'b1;
        state_nxt = (k_r == 2'd3) ? ST_POP : ST_NREAD;
      end

      // Robot cell walls arrive; start the neighbour choice.
      ST_CWALL: begin
        cwalls_nxt = wall_rd | border(rob_row_r, rob_col_r);
        k_nxt      = '0;
        found_nxt  = 1'b0;
        state_nxt  = ST_CAND;
      end

      // Candidates in the order west, south, east, north.
      ST_CAND: begin
        dist_ra = nb_idx;
        if (cwalls_r[~k_r]) begin
          k_nxt     = k_r + 1'b1;
          state_nxt = (k_r == 2'd3) ? ST_MOVE : ST_CAND;
        end else begin
          state_nxt = ST_CANDW;
        end
      end

      // Keep the strictly smaller distance, so earlier sides win ties.
      ST_CANDW: begin
        if (!found_r || dist_rd < best_r) begin
          best_nxt  = dist_rd;
          bdir_nxt  = ~k_r;
          found_nxt = 1'b1;
        end
        k_nxt     = k_r + 1'b1;
        state_nxt = (k_r == 2'd3) ? ST_MOVE : ST_CAND;
      end

      // Wall-follower choice straight from the sensed walls and the maze edge.
      ST_FOLLOW: begin
        found_nxt = fw_found;
        bdir_nxt  = fw_dir;
        state_nxt = ST_MOVE;
      end

      // Step the robot; an enclosed cell leaves it in place. The distance of the
      // cell the robot ends in is read here.
      ST_MOVE: begin
        if (found_r) begin
          rob_row_nxt  = nb_row;
          rob_col_nxt  = nb_col;
          rob_head_nxt = bdir_r;
          turn_nxt     = bdir_r - rob_head_r;
          dist_ra      = nb_idx;
        end else begin
          turn_nxt = TURN_NONE;
        end
        state_nxt = ST_DONE;
      end

      // Distance of the new cell arrives; load the result once the output is free.
      ST_DONE: begin
        if (!out_vld_r || out_ch.ready) begin
          out_vld_nxt = 1'b1;
          o_turn_nxt  = turn_r;
          o_head_nxt  = rob_head_r;
          o_row_nxt   = 4'(rob_row_r);
          o_col_nxt   = 4'(rob_col_r);
          o_goal_nxt  = goal_now;
          o_stuck_nxt = !found_r;
          o_dist_nxt  = dist_rd;
          state_nxt   = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.turn          = o_turn_r;
  assign out_ch.heading       = o_head_r;
  assign out_ch.new_row       = o_row_r;
  assign out_ch.new_col       = o_col_r;
  assign out_ch.at_goal       = o_goal_r;
  assign out_ch.stuck         = o_stuck_r;
  assign out_ch.cell_distance = o_dist_r;

  // An accepted item keeps the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("input ready right after an accepted item");

  // A stuck robot reports no turn.
  a_stuck_no_turn: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.stuck |-> out_ch.turn == TURN_NONE)
    else $error("stuck result with a turn");

  // The flood queue never grows past the cell count.
  a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r <= (CELL_W+1)'(NCELLS))
    else $error("flood queue overflow");

  // A neighbour check always follows its read.
  a_nchk_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_NCHK |-> $past(state_r) == ST_NREAD)
    else $error("neighbour check without read");

endmodule
